>>> hdl/tkm_pkg.sv
// Package for the top-k match list: slot and match records, request codes,
// sequencer states, action codes and default sizes. Used by tkm_match_unit
// and the top level. Depends on nothing else.
package tkm_pkg;

   parameter int SLOTS_DEFAULT = 16;

   parameter int DIST_W       = 32;
   parameter int SEED_INDEX_W = 16;
   parameter int CAND_INDEX_W = 20;
   parameter int FILE_ID_W    = 16;
   parameter int TIME_W       = 32;
   parameter int SLOT_W       = 6;
   parameter int ACTION_W     = 2;
   parameter int CSR_ADDR_W   = 3;

   parameter logic REQ_OFFER = 1'b0;
   parameter logic REQ_READ  = 1'b1;

   parameter logic [ACTION_W-1:0] ACT_NONE    = 2'd0;
   parameter logic [ACTION_W-1:0] ACT_INSERT  = 2'd1;
   parameter logic [ACTION_W-1:0] ACT_REPLACE = 2'd2;
   parameter logic [ACTION_W-1:0] ACT_SHIFT   = 2'd3;

   // Register index of exclusion_window, taken from the word address bit.
   parameter logic CSR_IDX_WINDOW = 1'b0;

   typedef struct packed {
      logic                    valid;
      logic [DIST_W-1:0]       distance;
      logic [SEED_INDEX_W-1:0] seed_index;
      logic [CAND_INDEX_W-1:0] cand_index;
      logic [FILE_ID_W-1:0]    file_id;
      logic [TIME_W-1:0]       seed_time;
      logic [TIME_W-1:0]       cand_time;
   } slot_type;

   parameter slot_type SLOT_EMPTY = '{
      valid:      1'b0,
      distance:   {DIST_W{1'b1}},
      seed_index: '0,
      cand_index: '0,
      file_id:    '0,
      seed_time:  '0,
      cand_time:  '0
   };

   typedef struct packed {
      logic greater;
      logic neighbour;
   } match_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_FINISH
   } state_type;

endpackage

>>> hdl/tkm_match_unit.sv
// Shared compare unit of the top-k match list: tests one stored slot against
// the offered candidate for ordering and for neighbour exclusion.
// Depends on tkm_pkg.
module tkm_match_unit (
   input  tkm_pkg::slot_type              slot_entry,
   input  logic [tkm_pkg::DIST_W-1:0]     cand_dist,
   input  logic [tkm_pkg::TIME_W-1:0]     seed_time,
   input  logic [tkm_pkg::TIME_W-1:0]     cand_time,
   input  logic [tkm_pkg::TIME_W-1:0]     window,
   output tkm_pkg::match_type             result
);

   logic [tkm_pkg::TIME_W:0]   diff_ext;
   logic [tkm_pkg::TIME_W-1:0] abs_diff;

   assign diff_ext = {1'b0, slot_entry.cand_time} - {1'b0, cand_time};
   assign abs_diff = diff_ext[tkm_pkg::TIME_W]
                     ? (~diff_ext[tkm_pkg::TIME_W-1:0] + {{(tkm_pkg::TIME_W-1){1'b0}}, 1'b1})
                     : diff_ext[tkm_pkg::TIME_W-1:0];

   always_comb begin
      result.greater   = slot_entry.distance > cand_dist;
      result.neighbour = slot_entry.valid && (slot_entry.seed_time == seed_time) &&
                         (abs_diff < window);
   end

endmodule

>>> hdl/top_k_match_list_with_exclusion.sv
// Top level of the top-k match list with neighbour exclusion: slot registers,
// scan sequencer, APB register port and result registers.
// Depends on tkm_pkg and tkm_match_unit.
//
// A transaction is accepted when start is high and busy is low. An offer
// (req_type 0) is scanned one slot per cycle through a single compare unit,
// stopping at the first neighbour or after the last slot. The update state
// then applies the insert, overwrite or partial shift to the slot registers,
// and the finish state loads the result registers. The result appears for
// exactly one cycle with rsp_strobe high; the receiver cannot stall it. A read
// (req_type 1) skips the scan and update states. busy stays high until the
// result strobe, and a new transaction can be accepted in the strobe cycle.
// Reset empties the list (all distances at maximum, all slots invalid) and
// clears the exclusion window. The window is written through the APB port at
// byte addresses 0 to 3; the user must write it only while the block is idle,
// which the block does not enforce. pready is always high.
module top_k_match_list_with_exclusion #(
   parameter int SLOTS = tkm_pkg::SLOTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               start,
   output logic                               busy,
   input  logic                               req_type,
   input  logic [tkm_pkg::DIST_W-1:0]         req_cand_dist,
   input  logic [tkm_pkg::SEED_INDEX_W-1:0]   req_seed_index,
   input  logic [tkm_pkg::CAND_INDEX_W-1:0]   req_cand_index,
   input  logic [tkm_pkg::FILE_ID_W-1:0]      req_file_id,
   input  logic [tkm_pkg::TIME_W-1:0]         req_seed_time,
   input  logic [tkm_pkg::TIME_W-1:0]         req_cand_time,
   input  logic [tkm_pkg::SLOT_W-1:0]         req_read_slot,

   output logic                               rsp_strobe,
   output logic [tkm_pkg::DIST_W-1:0]         rsp_threshold,
   output logic [tkm_pkg::ACTION_W-1:0]       rsp_action,
   output logic [tkm_pkg::SLOT_W-1:0]         rsp_slot,
   output logic                               rsp_rd_valid,
   output logic [tkm_pkg::DIST_W-1:0]         rsp_rd_dist,
   output logic [tkm_pkg::SEED_INDEX_W-1:0]   rsp_rd_seed_index,
   output logic [tkm_pkg::CAND_INDEX_W-1:0]   rsp_rd_cand_index,
   output logic [tkm_pkg::FILE_ID_W-1:0]      rsp_rd_file_id,
   output logic [tkm_pkg::TIME_W-1:0]         rsp_rd_seed_time,
   output logic [tkm_pkg::TIME_W-1:0]         rsp_rd_cand_time,

   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tkm_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   tkm_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   ins_ff, ins_in;
   logic               ins_found_ff, ins_found_in;
   logic [IDX_W-1:0]   nb_ff, nb_in;
   logic               nb_found_ff, nb_found_in;
   logic               is_read_ff, is_read_in;
   logic               rd_in_range_ff, rd_in_range_in;
   logic [tkm_pkg::SLOT_W-1:0] rd_slot_ff, rd_slot_in;
   tkm_pkg::slot_type  cand_ff, cand_in;
   logic [tkm_pkg::TIME_W-1:0] window_ff, window_in;
   tkm_pkg::slot_type  slot_ff [SLOTS];
   tkm_pkg::slot_type  slot_in [SLOTS];

   logic                          strobe_ff, strobe_in;
   logic [tkm_pkg::DIST_W-1:0]    threshold_ff, threshold_in;
   logic [tkm_pkg::ACTION_W-1:0]  action_ff, action_in;
   logic [tkm_pkg::SLOT_W-1:0]    rslot_ff, rslot_in;
   tkm_pkg::slot_type             rd_ff, rd_in;

   tkm_pkg::slot_type  cur_slot;
   tkm_pkg::match_type match;
   logic               accept;
   logic               csr_write;
   logic [IDX_W-1:0]   hi_idx;

   assign accept    = start && (state_ff == tkm_pkg::ST_IDLE);
   assign csr_write = psel && penable && pwrite;
   assign cur_slot  = slot_ff[cnt_ff];
   assign hi_idx    = nb_found_ff ? nb_ff : LAST_IDX;

   tkm_match_unit u_match (
      .slot_entry (cur_slot),
      .cand_dist  (cand_ff.distance),
      .seed_time  (cand_ff.seed_time),
      .cand_time  (cand_ff.cand_time),
      .window     (window_ff),
      .result     (match)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tkm_pkg::ST_IDLE: begin
            if (start) begin
               state_in = (req_type == tkm_pkg::REQ_READ) ? tkm_pkg::ST_FINISH
                                                          : tkm_pkg::ST_SCAN;
            end
         end
         tkm_pkg::ST_SCAN: begin
            if (match.neighbour || (cnt_ff == LAST_IDX)) begin
               state_in = tkm_pkg::ST_UPDATE;
            end
         end
         tkm_pkg::ST_UPDATE: state_in = tkm_pkg::ST_FINISH;
         tkm_pkg::ST_FINISH: state_in = tkm_pkg::ST_IDLE;
         default:            state_in = tkm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cnt_in         = cnt_ff;
      ins_in         = ins_ff;
      ins_found_in   = ins_found_ff;
      nb_in          = nb_ff;
      nb_found_in    = nb_found_ff;
      is_read_in     = is_read_ff;
      rd_in_range_in = rd_in_range_ff;
      rd_slot_in     = rd_slot_ff;
      cand_in        = cand_ff;
      slot_in        = slot_ff;
      strobe_in      = 1'b0;
      threshold_in   = threshold_ff;
      action_in      = action_ff;
      rslot_in       = rslot_ff;
      rd_in          = rd_ff;
      window_in      = window_ff;

      if (csr_write && (paddr[2] == tkm_pkg::CSR_IDX_WINDOW)) begin
         window_in = pwdata;
      end

      case (state_ff)
         tkm_pkg::ST_IDLE: begin
            if (accept) begin
               is_read_in           = (req_type == tkm_pkg::REQ_READ);
               rd_slot_in           = req_read_slot;
               rd_in_range_in       = {1'b0, req_read_slot} < (tkm_pkg::SLOT_W + 1)'(SLOTS);
               cnt_in               = rd_in_range_in ? req_read_slot[IDX_W-1:0] : '0;
               if (req_type == tkm_pkg::REQ_OFFER) begin
                  cnt_in = '0;
               end
               ins_found_in         = 1'b0;
               nb_found_in          = 1'b0;
               cand_in.valid        = 1'b1;
               cand_in.distance     = req_cand_dist;
               cand_in.seed_index   = req_seed_index;
               cand_in.cand_index   = req_cand_index;
               cand_in.file_id      = req_file_id;
               cand_in.seed_time    = req_seed_time;
               cand_in.cand_time    = req_cand_time;
            end
         end
         tkm_pkg::ST_SCAN: begin
            if (!ins_found_ff && match.greater) begin
               ins_in       = cnt_ff;
               ins_found_in = 1'b1;
            end
            if (match.neighbour) begin
               nb_in       = cnt_ff;
               nb_found_in = 1'b1;
            end else if (cnt_ff != LAST_IDX) begin
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         tkm_pkg::ST_UPDATE: begin
            if (ins_found_ff) begin
               for (int k = 0; k < SLOTS; k++) begin
                  if (IDX_W'(k) == ins_ff) begin
                     slot_in[k] = cand_ff;
                  end else if ((IDX_W'(k) > ins_ff) && (IDX_W'(k) <= hi_idx)) begin
                     slot_in[k] = slot_ff[(k > 0) ? k - 1 : 0];
                  end
               end
            end
         end
         tkm_pkg::ST_FINISH: begin
            strobe_in    = 1'b1;
            threshold_in = slot_ff[SLOTS-1].distance;
            rd_in        = '0;
            if (is_read_ff) begin
               action_in = tkm_pkg::ACT_NONE;
               rslot_in  = rd_slot_ff;
               if (rd_in_range_ff) begin
                  rd_in = cur_slot;
               end
            end else begin
               rslot_in = ins_found_ff ? tkm_pkg::SLOT_W'(ins_ff) : '0;
               if (!ins_found_ff) begin
                  action_in = tkm_pkg::ACT_NONE;
               end else if (!nb_found_ff) begin
                  action_in = tkm_pkg::ACT_INSERT;
               end else if (nb_ff == ins_ff) begin
                  action_in = tkm_pkg::ACT_REPLACE;
               end else begin
                  action_in = tkm_pkg::ACT_SHIFT;
               end
            end
         end
         default: begin
            strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= tkm_pkg::ST_IDLE;
         strobe_ff <= 1'b0;
         window_ff <= '0;
         for (int k = 0; k < SLOTS; k++) begin
            slot_ff[k] <= tkm_pkg::SLOT_EMPTY;
         end
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         window_ff <= window_in;
         slot_ff   <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff         <= cnt_in;
      ins_ff         <= ins_in;
      ins_found_ff   <= ins_found_in;
      nb_ff          <= nb_in;
      nb_found_ff    <= nb_found_in;
      is_read_ff     <= is_read_in;
      rd_in_range_ff <= rd_in_range_in;
      rd_slot_ff     <= rd_slot_in;
      cand_ff        <= cand_in;
      threshold_ff   <= threshold_in;
      action_ff      <= action_in;
      rslot_ff       <= rslot_in;
      rd_ff          <= rd_in;
   end

   assign busy              = (state_ff != tkm_pkg::ST_IDLE);
   assign rsp_strobe        = strobe_ff;
   assign rsp_threshold     = threshold_ff;
   assign rsp_action        = action_ff;
   assign rsp_slot          = rslot_ff;
   assign rsp_rd_valid      = rd_ff.valid;
   assign rsp_rd_dist       = rd_ff.distance;
   assign rsp_rd_seed_index = rd_ff.seed_index;
   assign rsp_rd_cand_index = rd_ff.cand_index;
   assign rsp_rd_file_id    = rd_ff.file_id;
   assign rsp_rd_seed_time  = rd_ff.seed_time;
   assign rsp_rd_cand_time  = rd_ff.cand_time;

   assign pready = 1'b1;
   assign prdata = (psel && !pwrite && (paddr[2] == tkm_pkg::CSR_IDX_WINDOW)) ? window_ff
                                                                              : 32'd0;

`ifndef ASSERT_OFF
   a_strobe_when_idle: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> (state_ff == tkm_pkg::ST_IDLE))
      else $error("Result strobe while the sequencer is busy.");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("Accepted transaction did not make the block busy.");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff)
      else $error("Result strobe lasted more than one cycle.");

   a_nb_not_before_ins: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == tkm_pkg::ST_UPDATE) && ins_found_ff && nb_found_ff) |->
      (nb_ff >= ins_ff))
      else $error("Neighbour found ahead of the insert position.");

   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tkm_pkg::ST_IDLE) |-> (!slot_ff[SLOTS-1].valid || slot_ff[0].valid))
      else $error("Last slot valid while the first slot is empty.");
`endif

endmodule
